[design/acab_pkg.sv]
`timescale 1ns / 1ps
// package for the aho-corasick automaton builder
// holds defaults, codes, controller states, datapath ops and status struct; no dependencies
package acab_pkg;

	localparam int ALPHABET_DEF = 32;
	localparam int NODES_DEF    = 128;
	localparam int CNT_W        = 9;
	localparam int ACNT_W       = 6;
	localparam logic [ACNT_W-1:0] ACNT_RESET = 6'd32;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	typedef enum logic [1:0] {
		FN_INSERT,
		FN_BUILD,
		FN_LOOKUP,
		FN_CLEAR
	} func_t;

	typedef enum logic [4:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_INS_RD,
		ST_INS_UPD,
		ST_LK_RD,
		ST_LK_CHK,
		ST_T_RD,
		ST_T_CAP,
		ST_B_INIT,
		ST_B_POP,
		ST_B_LINK,
		ST_B_SETU,
		ST_B_RDV,
		ST_B_RDU,
		ST_B_ACT,
		ST_CLR,
		ST_RESP,
		ST_CRESP
	} state_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_SWEEP,
		OP_LOAD,
		OP_INS_RD,
		OP_INS_UPD,
		OP_LK_RD,
		OP_LK_CHK,
		OP_T_RD,
		OP_T_CAP,
		OP_B_INIT,
		OP_B_POP,
		OP_B_LINK,
		OP_B_SETU,
		OP_B_RDV,
		OP_B_RDU,
		OP_B_ACT,
		OP_CLEAR,
		OP_RESP
	} op_t;

	typedef struct packed {
		logic sweep_last;
		logic sym_bad;
		logic lk_bad;
		logic bfs_empty;
		logic count_zero;
		logic id_last;
		logic out_busy;
	} dp_stat_t;

endpackage

[design/acab_ctrl.sv]
`timescale 1ns / 1ps
// controller state machine of the automaton builder
// sequences datapath ops from the item kind and datapath status; depends on acab_pkg
module acab_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  acab_pkg::func_t    func,
	output logic               s_tready,
	input  acab_pkg::dp_stat_t st,
	output acab_pkg::op_t      op
);
	import acab_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		op       = OP_NONE;
		s_tready = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				op = OP_SWEEP;
				if (st.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					op = OP_LOAD;
					case (func)
						FN_INSERT: state_d = ST_INS_RD;
						FN_BUILD:  state_d = ST_B_INIT;
						FN_LOOKUP: state_d = ST_LK_RD;
						default:   state_d = ST_CLR;
					endcase
				end
			end
			ST_INS_RD: begin
				op      = OP_INS_RD;
				state_d = st.sym_bad ? ST_T_RD : ST_INS_UPD;
			end
			ST_INS_UPD: begin
				op      = OP_INS_UPD;
				state_d = ST_T_RD;
			end
			ST_LK_RD: begin
				op      = OP_LK_RD;
				state_d = st.lk_bad ? ST_RESP : ST_LK_CHK;
			end
			ST_LK_CHK: begin
				op      = OP_LK_CHK;
				state_d = ST_T_RD;
			end
			ST_T_RD: begin
				op      = OP_T_RD;
				state_d = ST_T_CAP;
			end
			ST_T_CAP: begin
				op      = OP_T_CAP;
				state_d = ST_RESP;
			end
			ST_B_INIT: begin
				op      = OP_B_INIT;
				state_d = ST_B_POP;
			end
			ST_B_POP: begin
				if (st.bfs_empty) begin
					state_d = ST_RESP;
				end else begin
					op      = OP_B_POP;
					state_d = ST_B_LINK;
				end
			end
			ST_B_LINK: begin
				op      = OP_B_LINK;
				state_d = ST_B_SETU;
			end
			ST_B_SETU: begin
				op      = OP_B_SETU;
				state_d = st.count_zero ? ST_B_POP : ST_B_RDV;
			end
			ST_B_RDV: begin
				op      = OP_B_RDV;
				state_d = ST_B_RDU;
			end
			ST_B_RDU: begin
				op      = OP_B_RDU;
				state_d = ST_B_ACT;
			end
			ST_B_ACT: begin
				op      = OP_B_ACT;
				state_d = st.id_last ? ST_B_POP : ST_B_RDV;
			end
			ST_CLR: begin
				op      = OP_CLEAR;
				state_d = ST_CRESP;
			end
			ST_RESP: begin
				if (!st.out_busy) begin
					op      = OP_RESP;
					state_d = ST_IDLE;
				end
			end
			ST_CRESP: begin
				if (!st.out_busy) begin
					op      = OP_RESP;
					state_d = ST_SWEEP;
				end
			end
			default: begin
				state_d = ST_SWEEP;
			end
		endcase
	end

endmodule

[design/acab_dp.sv]
`timescale 1ns / 1ps
// datapath of the automaton builder: goto, link, mark and queue memories, counters,
// result and output registers; executes one op per cycle; depends on acab_pkg
module acab_dp #(
	parameter int ALPHABET = acab_pkg::ALPHABET_DEF,
	parameter int NODES    = acab_pkg::NODES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  acab_pkg::op_t      op,
	input  logic [4:0]         in_symbol,
	input  logic               in_pattern_end,
	input  logic [6:0]         in_from_state,
	input  logic               cfg_wr_en,
	input  logic [5:0]         cfg_wr_data,
	input  logic               m_tready,
	output logic               m_tvalid,
	output logic [6:0]         next_state,
	output logic               is_terminal,
	output logic [1:0]         status,
	output acab_pkg::dp_stat_t st
);
	import acab_pkg::*;

	localparam int NW     = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int SW     = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int CW     = NW + 1;
	localparam int GAW    = NW + SW;
	localparam int GDEPTH = 1 << GAW;
	localparam int LDEPTH = 1 << NW;

	// memories
	logic [NW-1:0] goto_mem  [GDEPTH];
	logic [NW-1:0] link_mem  [LDEPTH];
	logic          term_mem  [LDEPTH];
	logic [NW-1:0] queue_mem [NODES];

	logic [GAW-1:0] g_addr;
	logic [NW-1:0]  g_wdata;
	logic           g_we;
	logic           g_re;
	logic [NW-1:0]  g_rdata_q;
	logic [NW-1:0]  l_addr;
	logic [NW-1:0]  l_wdata;
	logic           l_we;
	logic           l_re;
	logic [NW-1:0]  l_rdata_q;
	logic [NW-1:0]  t_addr;
	logic           t_wdata;
	logic           t_we;
	logic           t_re;
	logic           t_rdata_q;
	logic [NW-1:0]  q_waddr;
	logic [NW-1:0]  q_wdata;
	logic           q_we;
	logic           q_re;
	logic [NW-1:0]  q_rdata_q;

	// control registers
	logic [CW-1:0]     node_cnt_q;
	logic [NW-1:0]     cursor_q;
	logic [ACNT_W-1:0] acount_q;
	logic [CW-1:0]     head_q;
	logic [CW-1:0]     tail_q;
	logic [GAW-1:0]    sweep_q;
	logic              out_valid_q;

	// working registers
	logic [4:0]    sym_q;
	logic [6:0]    from_q;
	logic          pend_q;
	logic [NW-1:0] v_q;
	logic [NW-1:0] u_q;
	logic [NW-1:0] c_q;
	logic [SW-1:0] id_q;
	logic [NW-1:0] nxt_q;
	logic          term_q;
	logic [1:0]    stat_q;
	logic [NW-1:0] out_next_q;
	logic          out_term_q;
	logic [1:0]    out_stat_q;

	logic [CNT_W-1:0] count;
	logic [SW-1:0]    sym_col;
	logic             sym_bad;
	logic             absent;
	logic             full;
	logic             ins_ok;
	logic [NW-1:0]    ins_node;
	logic             child_ok;
	logic [NW-1:0]    g_clean;
	logic [NW-1:0]    l_clean;

	assign count    = (CNT_W'(acount_q) > CNT_W'(ALPHABET)) ? CNT_W'(ALPHABET)
	                                                       : CNT_W'(acount_q);
	assign sym_col  = SW'(sym_q);
	assign sym_bad  = CNT_W'(sym_q) >= count;
	assign absent   = (g_rdata_q == '0) || (CW'(g_rdata_q) >= CW'(NODES));
	assign full     = node_cnt_q >= CW'(NODES);
	assign ins_ok   = !(absent && full);
	assign ins_node = absent ? node_cnt_q[NW-1:0] : g_rdata_q;
	assign child_ok = (c_q != '0) && (CW'(c_q) < CW'(NODES));
	assign g_clean  = (CW'(g_rdata_q) >= CW'(NODES)) ? '0 : g_rdata_q;
	assign l_clean  = (CW'(l_rdata_q) >= CW'(NODES)) ? '0 : l_rdata_q;

	always_comb begin
		st.sweep_last = &sweep_q;
		st.sym_bad    = sym_bad;
		st.lk_bad     = sym_bad || (int'(from_q) >= NODES);
		st.bfs_empty  = head_q == tail_q;
		st.count_zero = count == '0;
		st.id_last    = (CNT_W'(id_q) + CNT_W'(1)) == count;
		st.out_busy   = out_valid_q && !m_tready;
	end

	// memory port decode
	always_comb begin
		g_addr  = '0;
		g_wdata = '0;
		g_we    = 1'b0;
		g_re    = 1'b0;
		l_addr  = '0;
		l_wdata = '0;
		l_we    = 1'b0;
		l_re    = 1'b0;
		t_addr  = '0;
		t_wdata = 1'b0;
		t_we    = 1'b0;
		t_re    = 1'b0;
		q_waddr = '0;
		q_wdata = '0;
		q_we    = 1'b0;
		q_re    = 1'b0;
		case (op)
			OP_SWEEP: begin
				g_addr = sweep_q;
				g_we   = 1'b1;
				l_addr = sweep_q[NW-1:0];
				l_we   = 1'b1;
				t_addr = sweep_q[NW-1:0];
				t_we   = 1'b1;
			end
			OP_INS_RD: begin
				g_addr = {cursor_q, sym_col};
				g_re   = !sym_bad;
			end
			OP_INS_UPD: begin
				g_addr  = {cursor_q, sym_col};
				g_wdata = node_cnt_q[NW-1:0];
				g_we    = absent && !full;
				t_addr  = ins_node;
				t_wdata = 1'b1;
				t_we    = ins_ok && pend_q;
			end
			OP_LK_RD: begin
				g_addr = {NW'(from_q), sym_col};
				g_re   = !st.lk_bad;
			end
			OP_T_RD: begin
				t_addr = nxt_q;
				t_re   = 1'b1;
			end
			OP_B_INIT: begin
				q_we = 1'b1;
			end
			OP_B_POP: begin
				q_re = 1'b1;
			end
			OP_B_LINK: begin
				l_addr = q_rdata_q;
				l_re   = 1'b1;
			end
			OP_B_RDV: begin
				g_addr = {v_q, id_q};
				g_re   = 1'b1;
			end
			OP_B_RDU: begin
				g_addr = {u_q, id_q};
				g_re   = 1'b1;
			end
			OP_B_ACT: begin
				g_addr  = {v_q, id_q};
				g_wdata = g_rdata_q;
				g_we    = (c_q == '0);
				l_addr  = c_q;
				l_wdata = (v_q == '0) ? '0 : g_rdata_q;
				l_we    = child_ok;
				q_waddr = tail_q[NW-1:0];
				q_wdata = c_q;
				q_we    = child_ok && (tail_q < CW'(NODES));
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			goto_mem[g_addr] <= g_wdata;
		end
		if (g_re) begin
			g_rdata_q <= goto_mem[g_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			link_mem[l_addr] <= l_wdata;
		end
		if (l_re) begin
			l_rdata_q <= link_mem[l_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			term_mem[t_addr] <= t_wdata;
		end
		if (t_re) begin
			t_rdata_q <= term_mem[t_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			queue_mem[q_waddr] <= q_wdata;
		end
		if (q_re) begin
			q_rdata_q <= queue_mem[head_q[NW-1:0]];
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_cnt_q  <= CW'(1);
			cursor_q    <= '0;
			acount_q    <= ACNT_RESET;
			head_q      <= '0;
			tail_q      <= '0;
			sweep_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				acount_q <= cfg_wr_data;
			end
			case (op)
				OP_SWEEP: begin
					sweep_q <= sweep_q + GAW'(1);
				end
				OP_INS_UPD: begin
					if (absent && !full) begin
						node_cnt_q <= node_cnt_q + CW'(1);
					end
					if (ins_ok) begin
						cursor_q <= pend_q ? '0 : ins_node;
					end
				end
				OP_B_INIT: begin
					head_q <= '0;
					tail_q <= CW'(1);
				end
				OP_B_POP: begin
					head_q <= head_q + CW'(1);
				end
				OP_B_ACT: begin
					if (child_ok && (tail_q < CW'(NODES))) begin
						tail_q <= tail_q + CW'(1);
					end
				end
				OP_CLEAR: begin
					node_cnt_q <= CW'(1);
					cursor_q   <= '0;
					sweep_q    <= '0;
				end
				default: begin
				end
			endcase
			if (op == OP_RESP) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and result registers
	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: begin
				sym_q  <= in_symbol;
				from_q <= in_from_state;
				pend_q <= in_pattern_end;
			end
			OP_INS_RD: begin
				nxt_q  <= cursor_q;
				stat_q <= sym_bad ? STAT_RANGE : STAT_OK;
			end
			OP_INS_UPD: begin
				if (ins_ok) begin
					nxt_q <= ins_node;
				end else begin
					stat_q <= STAT_FULL;
				end
			end
			OP_LK_RD: begin
				nxt_q  <= '0;
				term_q <= 1'b0;
				stat_q <= st.lk_bad ? STAT_RANGE : STAT_OK;
			end
			OP_LK_CHK: begin
				nxt_q <= g_clean;
			end
			OP_T_CAP: begin
				term_q <= t_rdata_q;
			end
			OP_B_INIT, OP_CLEAR: begin
				nxt_q  <= '0;
				term_q <= 1'b0;
				stat_q <= STAT_OK;
			end
			OP_B_LINK: begin
				v_q <= q_rdata_q;
			end
			OP_B_SETU: begin
				u_q  <= l_clean;
				id_q <= '0;
			end
			OP_B_RDU: begin
				c_q <= g_rdata_q;
			end
			OP_B_ACT: begin
				id_q <= id_q + SW'(1);
			end
			OP_RESP: begin
				out_next_q <= nxt_q;
				out_term_q <= term_q;
				out_stat_q <= stat_q;
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid    = out_valid_q;
	assign next_state  = 7'(out_next_q);
	assign is_terminal = out_term_q;
	assign status      = out_stat_q;

endmodule

[design/aho_corasick_automaton_builder_top.sv]
`timescale 1ns / 1ps
// Aho-Corasick automaton builder over a node table. One item is worked on at a time;
// a finished result sits in an output register, so the next item is taken while it
// waits. An insert reads and updates the goto memory (no update when the symbol is out
// of range), then reads and captures the terminal mark; a lookup reads and checks the
// goto memory, then reads and captures the mark, or goes straight to the response when
// the symbol or node is out of range. The response state loads the output register
// and stalls while the previous result is still waiting there. The sequence is set by
// the single-port goto memory read followed by a read of the terminal-mark memory.
// Build pops, link-reads and sets up each node; per node and active symbol it does two
// goto reads and one update on the shared goto port. After reset and every clear item
// the tables are zeroed by a sweep of all 2**(clog2(NODES)+clog2(ALPHABET)) goto
// addresses (4096 at the defaults), accepting no item. Depends on acab_pkg, acab_ctrl and acab_dp.
module aho_corasick_automaton_builder_top #(
	parameter int ALPHABET = acab_pkg::ALPHABET_DEF,
	parameter int NODES    = acab_pkg::NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // symbol[4:0], from_state[11:5], zero fill
	input  logic        s_tlast,
	input  logic [1:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // next_state[6:0], is_terminal[7]
	output logic [1:0]  m_tuser,  // status
	input  logic        cfg_wr_en,
	input  logic [5:0]  cfg_wr_data
);
	import acab_pkg::*;

	op_t        op;
	dp_stat_t   st;
	logic [6:0] next_state;
	logic       is_terminal;
	logic [1:0] status;

	acab_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.func     (func_t'(s_tuser)),
		.s_tready (s_tready),
		.st       (st),
		.op       (op)
	);

	acab_dp #(
		.ALPHABET (ALPHABET),
		.NODES    (NODES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.op             (op),
		.in_symbol      (s_tdata[4:0]),
		.in_pattern_end (s_tlast),
		.in_from_state  (s_tdata[11:5]),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.m_tready       (m_tready),
		.m_tvalid       (m_tvalid),
		.next_state     (next_state),
		.is_terminal    (is_terminal),
		.status         (status),
		.st             (st)
	);

	assign m_tdata = {is_terminal, next_state};
	assign m_tuser = status;

	a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(op == OP_SWEEP) |-> !s_tready)
		else $error("item accepted during table sweep");

	a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second transaction accepted before first finished");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_FULL || m_tuser == STAT_RANGE))
		else $error("undefined status code on output");

endmodule

[dv/aho_corasick_automaton_builder_top_test.sv]
`timescale 1ns / 1ps
// self-checking testbench for aho_corasick_automaton_builder_top: directed table, then random trie
// inserts, link builds and lookup walks, checked against the expected values of typed rows or
// else an in-bench automaton predictor; depends on acab_pkg and aho_corasick_automaton_builder_top rtl
module aho_corasick_automaton_builder_top_test;
	import acab_pkg::*;

	localparam int NODES = NODES_DEF;
	localparam int ALPHA = ALPHABET_DEF;
	localparam int PLAN_ROWS = 25;

	typedef struct packed {
		logic [6:0] nxt;
		logic       term;
		logic [1:0] stat;
	} transition_t;

	typedef struct {
		bit          is_cfg;
		logic [5:0]  cfg_val;
		func_t       fn;
		logic [4:0]  sym;
		logic        pend;
		logic [6:0]  frm;
		bit          typed;
		transition_t want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_wr_en;
	logic [5:0]  cfg_wr_data;

	aho_corasick_automaton_builder_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	// automaton predictor state
	bit [6:0]    goto_tbl [NODES][ALPHA];
	bit          term_mark [NODES];
	bit [6:0]    sfx_link [NODES];
	int          node_cnt;
	int          cursor;
	bit [5:0]    alpha_reg;

	transition_t pending_transitions[$];
	transition_t last_prediction;
	transition_t head_exp;
	plan_row_t   plan [PLAN_ROWS];

	int errors;
	int n_items;
	int n_results;
	int n_builds;
	int n_full;
	int n_range;
	bit calm;
	bit hold_req;
	int gap_odds;

	function automatic int active_count();
		return (alpha_reg < ALPHA) ? int'(alpha_reg) : ALPHA;
	endfunction

	function automatic void wipe_automaton();
		for (int n = 0; n < NODES; n++) begin
			for (int s = 0; s < ALPHA; s++)
				goto_tbl[n][s] = '0;
			term_mark[n] = 1'b0;
			sfx_link[n] = '0;
		end
		node_cnt = 1;
		cursor = 0;
	endfunction

	function automatic void link_breadth_first();
		bit [6:0] bfs [NODES];
		int cnt;
		int head;
		int tail;
		int v;
		int u;
		int c;
		cnt = active_count();
		head = 0;
		tail = 1;
		bfs[0] = '0;
		while (head < tail) begin
			v = bfs[head];
			head++;
			u = sfx_link[v];
			for (int id = 0; id < cnt; id++) begin
				c = goto_tbl[v][id];
				if (c != 0) begin
					sfx_link[c] = (v == 0) ? 7'd0 : goto_tbl[u][id];
					if (tail < NODES) begin
						bfs[tail] = c[6:0];
						tail++;
					end
				end else begin
					goto_tbl[v][id] = goto_tbl[u][id];
				end
			end
		end
	endfunction

	function automatic transition_t advance_automaton(func_t fn, int sym, bit pend, int frm);
		transition_t r;
		int cnt;
		int c;
		bit full;
		r = '0;
		r.stat = STAT_OK;
		cnt = active_count();
		case (fn)
			FN_INSERT: begin
				full = 1'b0;
				if (sym >= cnt) begin
					r.stat = STAT_RANGE;
					r.nxt = cursor[6:0];
				end else begin
					c = goto_tbl[cursor][sym];
					if (c == 0) begin
						if (node_cnt >= NODES) begin
							full = 1'b1;
						end else begin
							c = node_cnt;
							node_cnt++;
							for (int s = 0; s < ALPHA; s++)
								goto_tbl[c][s] = '0;
							term_mark[c] = 1'b0;
							sfx_link[c] = '0;
							goto_tbl[cursor][sym] = c[6:0];
						end
					end
					if (full) begin
						r.stat = STAT_FULL;
						r.nxt = cursor[6:0];
					end else begin
						r.nxt = c[6:0];
						if (pend) begin
							term_mark[c] = 1'b1;
							cursor = 0;
						end else begin
							cursor = c;
						end
					end
				end
				r.term = term_mark[r.nxt];
			end
			FN_BUILD: begin
				link_breadth_first();
			end
			FN_LOOKUP: begin
				if (sym >= cnt) begin
					r.stat = STAT_RANGE;
				end else begin
					r.nxt = goto_tbl[frm][sym];
					r.term = term_mark[r.nxt];
				end
			end
			default: begin
				wipe_automaton();
			end
		endcase
		return r;
	endfunction

	task automatic offer_item(func_t fn, logic [4:0] sym, logic pend, logic [6:0] frm,
			bit typed, transition_t want);
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {4'd0, frm, sym};
		s_tlast <= pend;
		do @(posedge clk); while (!s_tready);
		last_prediction = advance_automaton(fn, sym, pend, frm);
		if (fn == FN_BUILD)
			n_builds++;
		if (last_prediction.stat == STAT_FULL)
			n_full++;
		if (last_prediction.stat == STAT_RANGE)
			n_range++;
		pending_transitions.insert(pending_transitions.size(),
			typed ? want : last_prediction);
		n_items++;
		if (!calm && gap_odds > 0 && $urandom_range(0, 99) < gap_odds) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	task automatic send(func_t fn, logic [4:0] sym, logic pend, logic [6:0] frm);
		offer_item(fn, sym, pend, frm, 1'b0, '0);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (pending_transitions.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_alphabet(logic [5:0] v);
		drain_results();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		alpha_reg = v;
		cfg_wr_en <= 1'b0;
	endtask

	function automatic logic [4:0] pick_symbol();
		if ($urandom_range(0, 11) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, active_count() - 1));
	endfunction

	task automatic insert_pattern(int len, bit allow_broken);
		bit broken;
		broken = allow_broken && ($urandom_range(0, 9) == 0);
		for (int k = 0; k < len; k++)
			send(FN_INSERT, pick_symbol(), (k == len - 1) && !broken,
				7'($urandom_range(0, 127)));
	endtask

	task automatic walk_text(int len);
		logic [6:0] at;
		at = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, node_cnt - 1)) : 7'd0;
		if ($urandom_range(0, 9) == 0)
			at = 7'($urandom_range(0, 127));
		for (int k = 0; k < len; k++) begin
			send(FN_LOOKUP, pick_symbol(), 1'($urandom_range(0, 1)), at);
			at = last_prediction.nxt;
		end
	endtask

	task automatic run_phase(logic [5:0] alpha, int quota, bit fill, bit squeeze);
		int start;
		int builds_here;
		int pick;
		write_alphabet(alpha);
		gap_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
		send(FN_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
			7'($urandom_range(0, 127)));
		start = n_items;
		builds_here = 0;
		if (squeeze) begin
			insert_pattern(4, 1'b0);
			hold_req = 1'b1;
			walk_text(24);
		end
		if (fill) begin
			while (node_cnt < NODES)
				insert_pattern($urandom_range(4, 9), 1'b0);
			for (int k = 0; k < 8; k++)
				send(FN_INSERT, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)), '0);
			send(FN_BUILD, '0, 1'b0, '0);
			builds_here++;
		end
		while (n_items - start < quota) begin
			pick = $urandom_range(0, 9);
			if (pick <= 3) begin
				insert_pattern($urandom_range(1, 6), 1'b1);
			end else if (pick <= 7) begin
				walk_text($urandom_range(1, 8));
			end else if (pick == 8 && builds_here < 2) begin
				send(FN_BUILD, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
					7'($urandom_range(0, 127)));
				builds_here++;
			end else begin
				send(($urandom_range(0, 1) == 0) ? FN_INSERT : FN_LOOKUP,
					5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)),
					7'($urandom_range(0, 127)));
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("Some tests failed");
		$finish;
	end

	// result sink with random stalls and one long hold-off
	initial begin
		@(posedge clk);
		forever begin
			if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (pending_transitions.size() == 0) begin
				errors++;
				$display("%0t: unexpected transaction: next %0d term %0b status %0d",
					$time, m_tdata[6:0], m_tdata[7], m_tuser);
			end else begin
				head_exp = pending_transitions.pop_front();
				if (m_tdata[6:0] !== head_exp.nxt) begin
					errors++;
					$display("%0t: next_state expected %0d actual %0d",
						$time, head_exp.nxt, m_tdata[6:0]);
				end
				if (m_tdata[7] !== head_exp.term) begin
					errors++;
					$display("%0t: is_terminal expected %0b actual %0b",
						$time, head_exp.term, m_tdata[7]);
				end
				if (m_tuser !== head_exp.stat) begin
					errors++;
					$display("%0t: status expected %0d actual %0d",
						$time, head_exp.stat, m_tuser);
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		errors = 0;
		n_items = 0;
		n_results = 0;
		n_builds = 0;
		n_full = 0;
		n_range = 0;
		calm = 1'b0;
		hold_req = 1'b0;
		gap_odds = 20;
		alpha_reg = ACNT_RESET;
		wipe_automaton();

		plan = '{
			'{0, '0, FN_LOOKUP, 5'd0,  1'b0, 7'd0,   1, '{7'd0, 1'b0, STAT_OK}},
			'{0, '0, FN_LOOKUP, 5'd31, 1'b1, 7'd127, 1, '{7'd0, 1'b0, STAT_OK}},
			'{0, '0, FN_INSERT, 5'd0,  1'b0, 7'd0,   1, '{7'd1, 1'b0, STAT_OK}},
			'{0, '0, FN_INSERT, 5'd31, 1'b1, 7'd127, 1, '{7'd2, 1'b1, STAT_OK}},
			'{0, '0, FN_INSERT, 5'd31, 1'b1, 7'd0,   1, '{7'd3, 1'b1, STAT_OK}},
			'{0, '0, FN_INSERT, 5'd0,  1'b0, 7'd0,   1, '{7'd1, 1'b0, STAT_OK}},
			'{0, '0, FN_INSERT, 5'd5,  1'b0, 7'd0,   1, '{7'd4, 1'b0, STAT_OK}},
			'{0, '0, FN_INSERT, 5'd31, 1'b1, 7'd0,   1, '{7'd5, 1'b1, STAT_OK}},
			'{0, '0, FN_BUILD,  5'd31, 1'b1, 7'd127, 1, '{7'd0, 1'b0, STAT_OK}},
			'{0, '0, FN_LOOKUP, 5'd31, 1'b0, 7'd1,   0, '0},
			'{0, '0, FN_LOOKUP, 5'd0,  1'b0, 7'd4,   0, '0},
			'{0, '0, FN_LOOKUP, 5'd7,  1'b0, 7'd2,   0, '0},
			'{0, '0, FN_INSERT, 5'd3,  1'b1, 7'd0,   0, '0},
			'{0, '0, FN_CLEAR,  5'd31, 1'b1, 7'd127, 1, '{7'd0, 1'b0, STAT_OK}},
			'{0, '0, FN_LOOKUP, 5'd0,  1'b0, 7'd1,   1, '{7'd0, 1'b0, STAT_OK}},
			'{1, 6'd1, FN_INSERT, 5'd0, 1'b0, 7'd0,  0, '0},
			'{0, '0, FN_INSERT, 5'd1,  1'b0, 7'd0,   1, '{7'd0, 1'b0, STAT_RANGE}},
			'{0, '0, FN_LOOKUP, 5'd1,  1'b0, 7'd0,   1, '{7'd0, 1'b0, STAT_RANGE}},
			'{0, '0, FN_INSERT, 5'd0,  1'b0, 7'd0,   1, '{7'd1, 1'b0, STAT_OK}},
			'{0, '0, FN_INSERT, 5'd0,  1'b1, 7'd0,   1, '{7'd2, 1'b1, STAT_OK}},
			'{0, '0, FN_BUILD,  5'd0,  1'b0, 7'd0,   1, '{7'd0, 1'b0, STAT_OK}},
			'{0, '0, FN_BUILD,  5'd0,  1'b0, 7'd0,   1, '{7'd0, 1'b0, STAT_OK}},
			'{0, '0, FN_LOOKUP, 5'd0,  1'b0, 7'd2,   0, '0},
			'{1, 6'd32, FN_INSERT, 5'd0, 1'b0, 7'd0, 0, '0},
			'{0, '0, FN_CLEAR,  5'd0,  1'b0, 7'd0,   1, '{7'd0, 1'b0, STAT_OK}}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_alphabet(plan[i].cfg_val);
			else
				offer_item(plan[i].fn, plan[i].sym, plan[i].pend, plan[i].frm,
					plan[i].typed, plan[i].want);
		end

		run_phase(6'd32, 118, 1'b0, 1'b0);
		run_phase(6'd2,  118, 1'b0, 1'b0);
		run_phase(6'd31, 118, 1'b0, 1'b1);
		run_phase(6'd1,  118, 1'b0, 1'b0);
		run_phase(6'd8,  118, 1'b0, 1'b0);
		run_phase(6'd32, 118, 1'b1, 1'b0);
		run_phase(6'd17, 118, 1'b0, 1'b0);
		run_phase(6'd4,  118, 1'b0, 1'b0);
		run_phase(6'd32, 118, 1'b0, 1'b0);
		run_phase(6'd16, 118, 1'b0, 1'b0);
		run_phase(6'd3,  118, 1'b0, 1'b0);
		drain_results();
		calm = 1'b1;
		run_phase(6'd32, 118, 1'b0, 1'b0);

		drain_results();
		repeat (50) @(posedge clk);
		$display("run covered %0d transactions and %0d results: %0d link builds,",
			n_items, n_results, n_builds);
		$display("%0d table-full inserts, %0d out-of-range items over 14 alphabet writes",
			n_full, n_range);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
